@@ sv/swdt_pkg.sv @@
// Shared types, codes and reset values of the Super I/O watchdog timer.
package swdt_pkg;

  // Field and register widths.
  localparam int ADDR_WIDTH = 16;
  localparam int BYTE_WIDTH = 8;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH = 2;

  // Default countdown width.
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Transaction kinds carried in the mode field.
  localparam logic [MODE_WIDTH-1:0] MODE_READ = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_PORT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PING_PORT = 2'd2;

  // Configuration register reset values.
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd1600;
  localparam logic [CFG_WIDTH-1:0] BASE_PORT_RESET = 16'h03F0;
  localparam logic [CFG_WIDTH-1:0] PING_PORT_RESET = 16'h0443;

  // Keys, register index and control byte values.
  localparam logic [BYTE_WIDTH-1:0] KEY_UNLOCK = 8'h87;
  localparam logic [BYTE_WIDTH-1:0] KEY_LOCK = 8'hAA;
  localparam logic [BYTE_WIDTH-1:0] CTRL_INDEX = 8'h14;
  localparam logic [BYTE_WIDTH-1:0] CTRL_RESET = 8'h8C;
  localparam int ARM_POS = 4;

  // Progress of the unlock key sequence.
  typedef enum logic [1:0] {
    STAGE_LOCKED,
    STAGE_ONE_KEY,
    STAGE_OPEN
  } unlock_stage_t;

  // One input transaction.
  typedef struct packed {
    logic [MODE_WIDTH-1:0] mode;
    logic [ADDR_WIDTH-1:0] port_address;
    logic [BYTE_WIDTH-1:0] write_data;
  } swdt_in_t;

  // One result transaction.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0] read_data;
    logic config_open;
    logic dog_armed;
    logic system_reset;
  } swdt_out_t;

  // Configuration register values as seen by the control logic.
  typedef struct packed {
    logic [CFG_WIDTH-1:0] timeout_ticks;
    logic [CFG_WIDTH-1:0] config_base_port;
    logic [CFG_WIDTH-1:0] ping_port;
  } swdt_cfg_t;

endpackage

@@ sv/superio_watchdog_timer_core.sv @@
// Top level of the Super I/O watchdog timer: input register, control logic and result register.
//
// Each transaction is a bus read, a bus write or a tick, and produces exactly one result.
// The transaction passes through the input register into the result register, and an
// output stall can hold it in either. A new transaction can be accepted every cycle: the
// input register feeds a single pass of decode and state update into the result register.
// The input side is stalled only while both registers are full and the result side is stalled.
// Two writes of 0x87 to the index port unlock configuration; 0xAA locks it again. Register
// 0x14 behind the data port (index port + 1) is the control byte, whose bit 4 arms the
// countdown. A read of the ping port reloads the countdown from timeout_ticks and clears
// system_reset; armed ticks count down and raise system_reset at zero. The user must write
// configuration registers only while no transaction is in flight; the block does not enforce it.
module superio_watchdog_timer_core #(
  parameter int COUNT_WIDTH = swdt_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  swdt_pkg::swdt_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output swdt_pkg::swdt_out_t                  out_data,
  input  logic                                 cfg_write,
  input  logic [swdt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [swdt_pkg::CFG_WIDTH-1:0]       cfg_data
);
  import swdt_pkg::*;

  swdt_cfg_t cfg;
  swdt_in_t item;
  logic item_valid;
  logic advance;
  swdt_out_t result;

  swdt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swdt_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // The held transaction moves on whenever the result register is free or draining.
  assign advance = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

@@ sv/swdt_cfg_regs.sv @@
// Configuration registers of the watchdog: timeout, index port base and ping port.
module swdt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [swdt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [swdt_pkg::CFG_WIDTH-1:0]       cfg_data,
  output swdt_pkg::swdt_cfg_t                  cfg
);
  import swdt_pkg::*;

  // Write decode; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.config_base_port <= BASE_PORT_RESET;
      cfg.ping_port <= PING_PORT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        CFG_BASE_PORT: cfg.config_base_port <= cfg_data;
        CFG_PING_PORT: cfg.ping_port <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/swdt_ctrl.sv @@
// Unlock sequence, control register and countdown state with the result of each transaction.
module swdt_ctrl #(
  parameter int COUNT_WIDTH = swdt_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  swdt_pkg::swdt_in_t  item,
  input  swdt_pkg::swdt_cfg_t cfg,
  output swdt_pkg::swdt_out_t result
);
  import swdt_pkg::*;

  localparam logic [31:0] TIMEOUT_RESET_EXT = 32'(TIMEOUT_RESET);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = TIMEOUT_RESET_EXT[COUNT_WIDTH-1:0];

  unlock_stage_t stage, stage_next;
  logic [BYTE_WIDTH-1:0] selected_index, selected_index_next;
  logic [BYTE_WIDTH-1:0] control_byte, control_byte_next;
  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  logic expired_flag, expired_flag_next;

  logic [ADDR_WIDTH-1:0] data_port;
  logic hit_index, hit_data, hit_ping, ctrl_sel;
  logic [31:0] reload_ext;
  logic [COUNT_WIDTH-1:0] reload_value;
  logic [COUNT_WIDTH-1:0] count_dec;

  // Address decode against the current port settings; the data port wraps at the top.
  assign data_port = cfg.config_base_port + ADDR_WIDTH'(1);
  assign hit_index = (item.port_address == cfg.config_base_port);
  assign hit_data = (item.port_address == data_port);
  assign hit_ping = (item.port_address == cfg.ping_port);
  assign ctrl_sel = (stage == STAGE_OPEN) && (selected_index == CTRL_INDEX);

  // The reload value is the timeout register masked to the countdown width.
  assign reload_ext = 32'(cfg.timeout_ticks);
  assign reload_value = reload_ext[COUNT_WIDTH-1:0];
  assign count_dec = (countdown != '0) ? countdown - COUNT_WIDTH'(1) : countdown;

  // Next state for the transaction in the input register.
  always_comb begin
    stage_next = stage;
    selected_index_next = selected_index;
    control_byte_next = control_byte;
    countdown_next = countdown;
    expired_flag_next = expired_flag;
    result.read_data = '0;
    unique case (item.mode)
      MODE_READ: begin
        if (hit_data && ctrl_sel) begin
          result.read_data = control_byte;
        end
        if (hit_ping) begin
          countdown_next = reload_value;
          expired_flag_next = 1'b0;
        end
      end
      MODE_WRITE: begin
        if (hit_index) begin
          if (stage != STAGE_OPEN) begin
            if (item.write_data == KEY_UNLOCK) begin
              stage_next = (stage == STAGE_LOCKED) ? STAGE_ONE_KEY : STAGE_OPEN;
            end else begin
              stage_next = STAGE_LOCKED;
            end
          end else if (item.write_data == KEY_LOCK) begin
            stage_next = STAGE_LOCKED;
          end else begin
            selected_index_next = item.write_data;
          end
        end
        // The index and data ports never share an address, so current state decides.
        if (hit_data && ctrl_sel) begin
          control_byte_next = item.write_data;
        end
      end
      MODE_TICK: begin
        if (control_byte[ARM_POS]) begin
          countdown_next = count_dec;
          if (count_dec == '0) begin
            expired_flag_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
    result.config_open = (stage_next == STAGE_OPEN);
    result.dog_armed = control_byte_next[ARM_POS];
    result.system_reset = expired_flag_next;
  end

  // State registers advance only when the transaction moves on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= STAGE_LOCKED;
      selected_index <= '0;
      control_byte <= CTRL_RESET;
      countdown <= COUNT_RESET;
      expired_flag <= 1'b0;
    end else if (step) begin
      stage <= stage_next;
      selected_index <= selected_index_next;
      control_byte <= control_byte_next;
      countdown <= countdown_next;
      expired_flag <= expired_flag_next;
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Super I/O watchdog timer core.
module tb;
  import swdt_pkg::*;

  localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_PERCENT = 20;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  swdt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  swdt_out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_TIMEOUT;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  // Shadow copy of the watchdog state and its configuration registers.
  logic [CFG_WIDTH-1:0] timeout_reg = TIMEOUT_RESET;
  logic [CFG_WIDTH-1:0] base_reg = BASE_PORT_RESET;
  logic [CFG_WIDTH-1:0] ping_reg = PING_PORT_RESET;
  unlock_stage_t key_stage = STAGE_LOCKED;
  logic [BYTE_WIDTH-1:0] sel_index = '0;
  logic [BYTE_WIDTH-1:0] ctrl_byte = CTRL_RESET;
  logic [COUNT_WIDTH-1:0] ticks_left = COUNT_WIDTH'(TIMEOUT_RESET);
  logic expired = 1'b0;

  // Status words predicted for accepted transactions, oldest first.
  swdt_out_t predicted_status_q[$];

  logic steady = 1'b0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int resets_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  superio_watchdog_timer_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Apply one bus access or tick to the shadow state and return the status it yields.
  function automatic swdt_out_t step_watchdog(input swdt_in_t acc);
    swdt_out_t status;
    logic [ADDR_WIDTH-1:0] data_port;
    data_port = base_reg + 16'd1;
    status = '0;
    case (acc.mode)
      MODE_READ: begin
        if (acc.port_address == data_port && key_stage == STAGE_OPEN &&
            sel_index == CTRL_INDEX) begin
          status.read_data = ctrl_byte;
        end
        if (acc.port_address == ping_reg) begin
          ticks_left = COUNT_WIDTH'(timeout_reg);
          expired = 1'b0;
        end
      end
      MODE_WRITE: begin
        if (acc.port_address == base_reg) begin
          if (key_stage != STAGE_OPEN) begin
            if (acc.write_data != KEY_UNLOCK) key_stage = STAGE_LOCKED;
            else if (key_stage == STAGE_LOCKED) key_stage = STAGE_ONE_KEY;
            else key_stage = STAGE_OPEN;
          end else if (acc.write_data == KEY_LOCK) begin
            key_stage = STAGE_LOCKED;
          end else begin
            sel_index = acc.write_data;
          end
        end
        if (acc.port_address == data_port && key_stage == STAGE_OPEN &&
            sel_index == CTRL_INDEX) begin
          ctrl_byte = acc.write_data;
        end
      end
      MODE_TICK: begin
        if (ctrl_byte[ARM_POS]) begin
          if (ticks_left != '0) ticks_left = ticks_left - COUNT_WIDTH'(1);
          if (ticks_left == '0) expired = 1'b1;
        end
      end
      default: begin
      end
    endcase
    status.config_open = (key_stage == STAGE_OPEN);
    status.dog_armed = ctrl_byte[ARM_POS];
    status.system_reset = expired;
    return status;
  endfunction

  // Send one transaction; called and returning at a falling edge.
  task automatic send_access(input logic [MODE_WIDTH-1:0] mode,
                             input logic [ADDR_WIDTH-1:0] addr,
                             input logic [BYTE_WIDTH-1:0] data);
    swdt_in_t acc;
    acc.mode = mode;
    acc.port_address = addr;
    acc.write_data = data;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = acc;
    do @(posedge clk); while (in_stall);
    predicted_status_q.push_back(step_watchdog(acc));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_read(input logic [ADDR_WIDTH-1:0] addr);
    send_access(MODE_READ, addr, 8'($urandom));
  endtask

  task automatic send_write(input logic [ADDR_WIDTH-1:0] addr,
                            input logic [BYTE_WIDTH-1:0] data);
    send_access(MODE_WRITE, addr, data);
  endtask

  // Ticks ignore address and data, so those carry random bits.
  task automatic send_tick();
    send_access(MODE_TICK, 16'($urandom), 8'($urandom));
  endtask

  // Write one register once the block has drained all outstanding transactions.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [CFG_WIDTH-1:0] value);
    in_valid = 1'b0;
    while (predicted_status_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (index)
      CFG_TIMEOUT: timeout_reg = value;
      CFG_BASE_PORT: base_reg = value;
      CFG_PING_PORT: ping_reg = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_ports(input logic [CFG_WIDTH-1:0] timeout,
                           input logic [CFG_WIDTH-1:0] base,
                           input logic [CFG_WIDTH-1:0] ping);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_BASE_PORT, base);
    write_reg(CFG_PING_PORT, ping);
    settings_used++;
  endtask

  // Locked and open port behavior, wrong keys, register select and arming.
  task automatic test_port_access();
    send_read(PING_PORT_RESET);
    send_tick();
    send_access(MODE_UNUSED, 16'hFFFF, 8'hFF);
    send_write(base_reg, 8'h11);
    send_read(base_reg + 16'd1);
    send_write(base_reg + 16'd1, 8'h9C);
    send_write(base_reg, KEY_UNLOCK);
    send_write(base_reg, 8'h00);
    send_write(base_reg, KEY_UNLOCK);
    send_write(base_reg, KEY_UNLOCK);
    send_write(base_reg, 8'h00);
    send_read(base_reg + 16'd1);
    send_write(base_reg + 16'd1, 8'hFF);
    send_write(base_reg, CTRL_INDEX);
    send_read(base_reg + 16'd1);
    send_write(ping_reg, 8'hFF);
    send_write(base_reg + 16'd1, 8'h9C);
    send_read(base_reg + 16'd1);
    send_tick();
    send_write(base_reg, KEY_LOCK);
    send_read(base_reg + 16'd1);
  endtask

  // Short and zero timeouts expire the armed countdown; a ping clears the reset.
  task automatic test_expiry();
    write_reg(CFG_TIMEOUT, 16'd2);
    send_read(ping_reg);
    repeat (3) send_tick();
    send_read(ping_reg);
    write_reg(CFG_TIMEOUT, 16'd0);
    send_read(ping_reg);
    send_tick();
    send_read(ping_reg);
  endtask

  // A configuration session, sometimes with a wrong key or another register selected.
  task automatic run_config_session();
    send_write(base_reg, ($urandom_range(9) == 0) ? 8'($urandom) : KEY_UNLOCK);
    send_write(base_reg, KEY_UNLOCK);
    send_write(base_reg, ($urandom_range(5) == 0) ? 8'($urandom) : CTRL_INDEX);
    send_read(base_reg + 16'd1);
    if ($urandom_range(3) != 0) send_write(base_reg + 16'd1, 8'($urandom));
    send_read(base_reg + 16'd1);
    if ($urandom_range(3) != 0) send_write(base_reg, KEY_LOCK);
  endtask

  function automatic logic [ADDR_WIDTH-1:0] pick_port();
    case ($urandom_range(3))
      0: return base_reg;
      1: return base_reg + 16'd1;
      2: return ping_reg;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed sessions, pings and tick bursts, with random noise mixed in.
  task automatic run_random_traffic(input int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        run_config_session();
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 12)) send_tick();
      end else if (pick < 60) begin
        send_read(ping_reg);
      end else begin
        send_access(MODE_WIDTH'($urandom), pick_port(), 8'($urandom));
      end
    end
  endtask

  // Random traffic under several port and timeout settings, extremes included.
  task automatic test_random_settings();
    logic [CFG_WIDTH-1:0] base;
    set_ports(16'd5, BASE_PORT_RESET, PING_PORT_RESET);
    run_random_traffic(250);
    set_ports(16'd0, 16'hFFFF, 16'h0000);
    run_random_traffic(250);
    set_ports(16'hFFFF, 16'h0000, 16'hFFFF);
    run_random_traffic(200);
    set_ports(16'd1, 16'h002E, 16'h002F);
    run_random_traffic(250);
    set_ports(16'd3, 16'h004E, 16'h004E);
    run_random_traffic(250);
    base = 16'($urandom);
    set_ports(16'($urandom_range(1, 40)), base,
              ($urandom_range(1) == 0) ? base + 16'd1 : 16'($urandom));
    run_random_traffic(150);
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_full_rate();
    set_ports(16'd4, BASE_PORT_RESET, PING_PORT_RESET);
    steady = 1'b1;
    run_random_traffic(300);
    steady = 1'b0;
  endtask

  // Result side stalls at random except during the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    swdt_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_status_q.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        error_count++;
      end else begin
        want = predicted_status_q.pop_front();
        results_checked++;
        if (out_data.system_reset === 1'b1) resets_seen++;
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
          error_count++;
        end
        if (out_data.config_open !== want.config_open) begin
          $error("config_open: expected %0b, got %0b", want.config_open,
                 out_data.config_open);
          error_count++;
        end
        if (out_data.dog_armed !== want.dog_armed) begin
          $error("dog_armed: expected %0b, got %0b", want.dog_armed, out_data.dog_armed);
          error_count++;
        end
        if (out_data.system_reset !== want.system_reset) begin
          $error("system_reset: expected %0b, got %0b", want.system_reset,
                 out_data.system_reset);
          error_count++;
        end
      end
    end
  end

  // End the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("superio_watchdog_timer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_port_access();
    test_expiry();
    test_random_settings();
    test_full_rate();
    in_valid = 1'b0;
    while (predicted_status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d transactions under %0d register settings; %0d results checked,",
             items_sent, settings_used, results_checked);
    $display("%0d of them with the system reset raised.", resets_seen);
    if (error_count == 0) begin
      $display("superio_watchdog_timer_core: match");
    end else begin
      $display("superio_watchdog_timer_core: mismatch");
    end
    $finish;
  end
endmodule
